>>> rtl/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the distance-vector route table
// Table geometry, field widths, operation and status codes, and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IN_IDX_W = 4;
    localparam int ID_W     = 8;
    localparam int DIST_W   = 16;

    localparam logic [DIST_W-1:0] DIST_INF        = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX_FINITE = DIST_INF - DIST_W'(1);

    typedef enum logic [1:0] {
        OP_OFFER  = 2'd0,
        OP_ADVERT = 2'd1,
        OP_FAIL   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_IMPROVED    = 3'd1,
        ST_KEPT        = 3'd2,
        ST_FULL        = 3'd3,
        ST_IGNORED     = 3'd4,
        ST_INVALIDATED = 3'd5,
        ST_READ        = 3'd6
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic             load;         // capture the input transaction
        logic             scan_en;      // search pass over slot idx
        logic             decide;       // resolve the operation, update the table
        logic             inval_en;     // invalidation pass over slot idx
        logic             result_load;  // move the result into the output register
        logic [IDX_W-1:0] idx;
    } drt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic dest_found;
    } drt_stat_t;

endpackage

>>> rtl/drt_datapath.sv
// ----------------------------------------------------------------------------
// drt_datapath: route table storage, search logic and result registers
// Holds the slot table in flip-flops with a single read port, captures the
// search results of one pass, applies inserts, improvements and
// invalidations, and keeps the output register.
// ----------------------------------------------------------------------------
module drt_datapath import drt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  drt_cmd_t            cmd,
    output drt_stat_t           stat,
    input  logic [1:0]          s_op,
    input  logic [ID_W-1:0]     s_dest_id,
    input  logic [ID_W-1:0]     s_via_id,
    input  logic [DIST_W-1:0]   s_distance,
    input  logic [IN_IDX_W-1:0] s_entry_index,
    output logic [2:0]          m_status,
    output logic                m_entry_used,
    output logic [ID_W-1:0]     m_entry_dest,
    output logic [DIST_W-1:0]   m_entry_distance,
    output logic                m_hop_valid,
    output logic [ID_W-1:0]     m_hop_id
);

    logic              slot_used_reg     [ENTRIES];
    logic [ID_W-1:0]   slot_dest_reg     [ENTRIES];
    logic [DIST_W-1:0] slot_distance_reg [ENTRIES];
    logic              slot_hop_valid_reg[ENTRIES];
    logic [ID_W-1:0]   slot_hop_reg      [ENTRIES];

    op_t                 op_reg;
    logic [ID_W-1:0]     dest_id_reg;
    logic [ID_W-1:0]     via_id_reg;
    logic [DIST_W-1:0]   distance_reg;
    logic [IN_IDX_W-1:0] entry_index_reg;

    logic              dfound_reg;
    logic [IDX_W-1:0]  dpos_reg;
    logic [DIST_W-1:0] dpos_dist_reg;
    logic              dpos_hopv_reg;
    logic [ID_W-1:0]   dpos_hop_reg;
    logic              vfound_reg;
    logic [DIST_W-1:0] vdist_reg;
    logic              ffound_reg;
    logic [IDX_W-1:0]  fpos_reg;

    logic [2:0]        res_status_reg;
    logic              res_used_reg;
    logic [ID_W-1:0]   res_dest_reg;
    logic [DIST_W-1:0] res_dist_reg;
    logic              res_hopv_reg;
    logic [ID_W-1:0]   res_hop_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic              in_range;
    logic              rd_used;
    logic [ID_W-1:0]   rd_dest;
    logic [DIST_W-1:0] rd_dist;
    logic              rd_hopv;
    logic [ID_W-1:0]   rd_hop;
    logic              hit_dest;
    logic              hit_via;
    logic              hit_hop;

    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] off_dist;
    logic              adv_ignore;
    logic              ins_en;
    logic              imp_en;
    status_t           dec_status;
    logic              dec_used;
    logic [ID_W-1:0]   dec_dest;
    logic [DIST_W-1:0] dec_dist;
    logic              dec_hopv;
    logic [ID_W-1:0]   dec_hop;

    // single read port: search counter, or the requested slot on a read
    assign in_range = (int'(entry_index_reg) < ENTRIES);
    assign rd_addr  = (op_reg == OP_READ) ? IDX_W'(entry_index_reg) : cmd.idx;
    assign rd_used  = slot_used_reg[rd_addr];
    assign rd_dest  = slot_dest_reg[rd_addr];
    assign rd_dist  = slot_distance_reg[rd_addr];
    assign rd_hopv  = slot_hop_valid_reg[rd_addr];
    assign rd_hop   = slot_hop_reg[rd_addr];

    assign hit_dest = rd_used && (rd_dest == dest_id_reg);
    assign hit_via  = rd_used && (rd_dest == via_id_reg);
    assign hit_hop  = rd_hopv && (rd_hop == dest_id_reg);

    assign stat.dest_found = dfound_reg;

    always_comb begin
        sum      = {1'b0, distance_reg} + {1'b0, vdist_reg};
        off_dist = distance_reg;
        if (op_reg == OP_ADVERT) begin
            off_dist = (sum >= {1'b0, DIST_INF}) ? DIST_MAX_FINITE : sum[DIST_W-1:0];
        end
        adv_ignore = (op_reg == OP_ADVERT) &&
                     ((distance_reg == DIST_INF) || !vfound_reg || (vdist_reg == DIST_INF));
        ins_en     = 1'b0;
        imp_en     = 1'b0;
        dec_status = ST_IGNORED;
        dec_used   = 1'b0;
        dec_dest   = '0;
        dec_dist   = '0;
        dec_hopv   = 1'b0;
        dec_hop    = '0;
        unique case (op_reg) inside
            OP_OFFER, OP_ADVERT: begin
                if (adv_ignore) begin
                    dec_status = ST_IGNORED;
                end else if (!dfound_reg) begin
                    if (ffound_reg) begin
                        ins_en     = 1'b1;
                        dec_status = ST_INSERTED;
                    end else begin
                        dec_status = ST_FULL;
                    end
                end else if (dpos_dist_reg > off_dist) begin
                    imp_en     = 1'b1;
                    dec_status = ST_IMPROVED;
                end else begin
                    dec_status = ST_KEPT;
                end
            end
            OP_FAIL: begin
                if (dfound_reg) begin
                    dec_status = ST_INVALIDATED;
                    dec_hopv   = dpos_hopv_reg;
                    dec_hop    = dpos_hop_reg;
                end
            end
            OP_READ: begin
                dec_status = ST_READ;
                if (in_range) begin
                    dec_used = rd_used;
                    dec_dest = rd_dest;
                    dec_dist = rd_dist;
                    dec_hopv = rd_hopv;
                    dec_hop  = rd_hop;
                end else begin
                    dec_dist = DIST_INF;
                end
            end
            default: begin
                dec_status = ST_IGNORED;
            end
        endcase
    end

    // route table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used_reg[i]      <= 1'b0;
                slot_dest_reg[i]      <= '0;
                slot_distance_reg[i]  <= DIST_INF;
                slot_hop_valid_reg[i] <= 1'b0;
                slot_hop_reg[i]       <= '0;
            end
        end else begin
            if (cmd.decide && ins_en) begin
                slot_used_reg[fpos_reg]      <= 1'b1;
                slot_dest_reg[fpos_reg]      <= dest_id_reg;
                slot_distance_reg[fpos_reg]  <= off_dist;
                slot_hop_valid_reg[fpos_reg] <= 1'b1;
                slot_hop_reg[fpos_reg]       <= via_id_reg;
            end
            if (cmd.decide && imp_en) begin
                slot_distance_reg[dpos_reg]  <= off_dist;
                slot_hop_valid_reg[dpos_reg] <= 1'b1;
                slot_hop_reg[dpos_reg]       <= via_id_reg;
            end
            if (cmd.inval_en && (hit_dest || hit_hop)) begin
                slot_distance_reg[rd_addr]  <= DIST_INF;
                slot_hop_valid_reg[rd_addr] <= 1'b0;
                slot_hop_reg[rd_addr]       <= '0;
            end
        end
    end

    // transaction capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_READ;
        end else if (cmd.load) begin
            op_reg <= op_t'(s_op);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dest_id_reg     <= s_dest_id;
            via_id_reg      <= s_via_id;
            distance_reg    <= s_distance;
            entry_index_reg <= s_entry_index;
        end
    end

    // first-hit search results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dfound_reg <= 1'b0;
            vfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
        end else if (cmd.load) begin
            dfound_reg <= 1'b0;
            vfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
        end else if (cmd.scan_en) begin
            if (hit_dest && !dfound_reg) begin
                dfound_reg <= 1'b1;
            end
            if (hit_via && !vfound_reg) begin
                vfound_reg <= 1'b1;
            end
            if (!rd_used && !ffound_reg) begin
                ffound_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_en) begin
            if (hit_dest && !dfound_reg) begin
                dpos_reg      <= rd_addr;
                dpos_dist_reg <= rd_dist;
                dpos_hopv_reg <= rd_hopv;
                dpos_hop_reg  <= rd_hop;
            end
            if (hit_via && !vfound_reg) begin
                vdist_reg <= rd_dist;
            end
            if (!rd_used && !ffound_reg) begin
                fpos_reg <= rd_addr;
            end
        end
    end

    // pending result, then output register
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            res_status_reg <= dec_status;
            res_used_reg   <= dec_used;
            res_dest_reg   <= dec_dest;
            res_dist_reg   <= dec_dist;
            res_hopv_reg   <= dec_hopv;
            res_hop_reg    <= dec_hop;
        end
        if (cmd.result_load) begin
            m_status         <= res_status_reg;
            m_entry_used     <= res_used_reg;
            m_entry_dest     <= res_dest_reg;
            m_entry_distance <= res_dist_reg;
            m_hop_valid      <= res_hopv_reg;
            m_hop_id         <= res_hop_reg;
        end
    end

endmodule

>>> rtl/drt_ctrl.sv
// ----------------------------------------------------------------------------
// drt_ctrl: operation sequencer of the route table
// Steps the slot counter through the search and invalidation passes, issues
// datapath commands and runs both channel handshakes.
// ----------------------------------------------------------------------------
module drt_ctrl import drt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    output logic       m_valid,
    input  logic       m_ready,
    output drt_cmd_t   cmd,
    input  drt_stat_t  stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_CLEAR,
        S_RESULT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t           state_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             fail_reg;
    logic             m_valid_reg;
    logic             out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd             = '0;
        cmd.idx         = cnt_reg;
        cmd.load        = s_valid && s_ready;
        cmd.scan_en     = (state_reg == S_SCAN);
        cmd.decide      = (state_reg == S_DECIDE);
        cmd.inval_en    = (state_reg == S_CLEAR);
        cmd.result_load = (state_reg == S_RESULT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            fail_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (s_valid) begin
                        fail_reg  <= (op_t'(s_op) == OP_FAIL);
                        state_reg <= (op_t'(s_op) == OP_READ) ? S_DECIDE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                    if (cnt_reg == LAST_IDX) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    cnt_reg <= '0;
                    state_reg <= (fail_reg && stat.dest_found) ? S_CLEAR : S_RESULT;
                end
                S_CLEAR: begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                    if (cnt_reg == LAST_IDX) begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/distance_vector_route_table.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table: distance-vector routing table, top level
// Sixteen-slot table of destination, distance and next hop, updated by direct
// offers, neighbor advertisements and router failures, and read by slot.
// ----------------------------------------------------------------------------
// Usage: every input transaction yields exactly one result transaction, in
// order. The block takes one transaction at a time; s_ready is high only
// while it is idle. Timing is set by the table's single read port, which a
// slot counter walks one slot per cycle. A read goes from the accepting
// idle step straight to the decide and result steps; a direct offer, an
// advertisement or a failure of an unknown router first makes a search
// pass over all slots, and a failure of a known router adds a second pass
// that marks its entry and every route through it unreachable. m_valid
// rises when the result step loads the output register. A finished result
// waits in the output register while m_ready is low; the next transaction is
// accepted meanwhile and holds only at its own result step. Distances are
// 16 bits with all ones meaning unreachable; an advertised sum saturates at
// the largest finite distance.
// ----------------------------------------------------------------------------
module distance_vector_route_table import drt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    input  logic [ID_W-1:0]     s_dest_id,
    input  logic [ID_W-1:0]     s_via_id,
    input  logic [DIST_W-1:0]   s_distance,
    input  logic [IN_IDX_W-1:0] s_entry_index,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic                m_entry_used,
    output logic [ID_W-1:0]     m_entry_dest,
    output logic [DIST_W-1:0]   m_entry_distance,
    output logic                m_hop_valid,
    output logic [ID_W-1:0]     m_hop_id
);

    drt_cmd_t  cmd;
    drt_stat_t stat;

    // Sequencer: accept, search pass (skipped on reads), decide, optional
    // invalidation pass, hand off to the output register.
    drt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // Table, first-hit search registers, offer arithmetic and result payload.
    drt_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_op             (s_op),
        .s_dest_id        (s_dest_id),
        .s_via_id         (s_via_id),
        .s_distance       (s_distance),
        .s_entry_index    (s_entry_index),
        .m_status         (m_status),
        .m_entry_used     (m_entry_used),
        .m_entry_dest     (m_entry_dest),
        .m_entry_distance (m_entry_distance),
        .m_hop_valid      (m_hop_valid),
        .m_hop_id         (m_hop_id)
    );

endmodule

>>> rtl/drt_checker.sv
// ----------------------------------------------------------------------------
// drt_checker: port-level assertions for the route table
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module drt_checker import drt_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_status,
    input logic              m_entry_used,
    input logic [ID_W-1:0]   m_entry_dest,
    input logic [DIST_W-1:0] m_entry_distance,
    input logic              m_hop_valid,
    input logic [ID_W-1:0]   m_hop_id
);

    // hold a stalled result
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_hop_id))
        else $error("result changed or dropped while stalled");

    // one transaction at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while busy");

    // entry fields are only carried by reads
    a_entry_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_READ) |->
            !m_entry_used && (m_entry_dest == '0) && (m_entry_distance == '0))
        else $error("entry fields set on a non-read result");

    // a hop only comes with reads and invalidations
    a_hop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_READ) && (m_status != ST_INVALIDATED) |->
            !m_hop_valid && (m_hop_id == '0))
        else $error("hop reported on an update result");

    // a cleared hop is always stored as zero
    a_hop_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hop_valid |-> (m_hop_id == '0))
        else $error("hop id set without hop valid");

endmodule

bind distance_vector_route_table drt_checker u_drt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_entry_used     (m_entry_used),
    .m_entry_dest     (m_entry_dest),
    .m_entry_distance (m_entry_distance),
    .m_hop_valid      (m_hop_valid),
    .m_hop_id         (m_hop_id)
);
